### rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int MAX_BLOCKS_DEF   = 256;

  localparam int OFFSET_OUT_W = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_NULL     = 3'd3;
  localparam logic [2:0] ST_OUTSIDE  = 3'd4;
  localparam logic [2:0] ST_DOUBLE   = 3'd5;
  localparam logic [2:0] ST_UNKNOWN  = 3'd6;

  typedef struct packed {
    logic        opcode;
    logic [31:0] req_size;
    logic [31:0] data_offset;
    logic        null_pointer;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [OFFSET_OUT_W-1:0] alloc_offset;
  } res_t;

endpackage

### rtl/ffa_table.sv
module ffa_table #(
  parameter int AW = 8,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ffa_alu.sv
module ffa_alu #(
  parameter int W = 17
) (
  input  logic         sub,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W:0]   res
);

  // res[W] is the carry, or the borrow on subtract
  always_comb begin
    if (sub) begin
      res = {1'b0, a} - {1'b0, b};
    end else begin
      res = {1'b0, a} + {1'b0, b};
    end
  end

endmodule

### rtl/ffa_ctrl.sv
module ffa_ctrl #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 32,
  parameter int MAX_BLOCKS   = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  ffa_pkg::req_t req,
  output logic          ready,
  output logic          res_valid,
  output ffa_pkg::res_t res,
  input  logic          res_take
);
  import ffa_pkg::*;

  localparam int OW = $clog2(HEAP_BYTES + 1);
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int DW = 2 * OW + 1;

  localparam logic [OW-1:0] HDR = OW'(HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_SC_RD = 5'd2;
  localparam logic [4:0] S_SC_CK = 5'd3;
  localparam logic [4:0] S_UP_RD = 5'd4;
  localparam logic [4:0] S_UP_WR = 5'd5;
  localparam logic [4:0] S_SP_A  = 5'd6;
  localparam logic [4:0] S_SP_B  = 5'd7;
  localparam logic [4:0] S_SP_C  = 5'd8;
  localparam logic [4:0] S_OFS   = 5'd9;
  localparam logic [4:0] S_FN_RD = 5'd10;
  localparam logic [4:0] S_FN_CK = 5'd11;
  localparam logic [4:0] S_FN_MG = 5'd12;
  localparam logic [4:0] S_F_WR  = 5'd13;
  localparam logic [4:0] S_FP_RD = 5'd14;
  localparam logic [4:0] S_FP_CK = 5'd15;
  localparam logic [4:0] S_FP_MG = 5'd16;
  localparam logic [4:0] S_CL_RD = 5'd17;
  localparam logic [4:0] S_CL_WR = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [4:0]    state_r, state_nxt;
  logic          op_r, op_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          ret_done_r, ret_done_nxt;
  logic [OW-1:0] need_r, need_nxt;
  logic [OW-1:0] key_r, key_nxt;
  logic [OW-1:0] diff_r, diff_nxt;
  logic [OW-1:0] tmp_r, tmp_nxt;
  logic [OW-1:0] e_start_r, e_start_nxt;
  logic [OW-1:0] e_bytes_r, e_bytes_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [OW-1:0] ofs_r, ofs_nxt;

  logic          wr_en, rd_en;
  logic [CW-1:0] wr_idx, rd_idx;
  logic [DW-1:0] wr_data, rd_data;
  logic [OW-1:0] rd_start, rd_bytes;
  logic          rd_free;

  logic          alu_sub;
  logic [OW-1:0] alu_a, alu_b;
  logic [OW:0]   alu_res;

  logic [CW-1:0] i_inc, i_dec, k_inc, k_dec;
  logic [OW+OFFSET_OUT_W-1:0] ofs_ext;

  assign rd_start = rd_data[2*OW:OW+1];
  assign rd_bytes = rd_data[OW:1];
  assign rd_free  = rd_data[0];

  assign i_inc = i_r + 1'b1;
  assign i_dec = i_r - 1'b1;
  assign k_inc = k_r + 1'b1;
  assign k_dec = k_r - 1'b1;

  ffa_table #(.AW(AW), .DW(DW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  ffa_alu #(.W(OW)) u_alu (
    .sub (alu_sub),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  always_comb begin
    alu_sub = 1'b0;
    alu_a   = e_start_r;
    alu_b   = HDR;
    unique case (state_r)
      S_IDLE: begin
        alu_sub = req.opcode;
        alu_a   = (req.opcode == OP_FREE) ? req.data_offset[OW-1:0] : req.req_size[OW-1:0];
      end
      S_SC_CK: begin
        alu_sub = 1'b1;
        alu_a   = rd_bytes;
        alu_b   = need_r;
      end
      S_SP_A:  alu_b = need_r;
      S_FN_CK: alu_a = rd_bytes;
      S_FN_MG, S_FP_MG: begin
        alu_a = tmp_r;
        alu_b = e_bytes_r;
      end
      S_FP_CK: alu_a = e_bytes_r;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    count_nxt    = count_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    ret_done_nxt = ret_done_r;
    need_nxt     = need_r;
    key_nxt      = key_r;
    diff_nxt     = diff_r;
    tmp_nxt      = tmp_r;
    e_start_nxt  = e_start_r;
    e_bytes_nxt  = e_bytes_r;
    st_nxt       = st_r;
    ofs_nxt      = ofs_r;
    wr_en        = 1'b0;
    wr_idx       = i_r;
    wr_data      = {e_start_r, e_bytes_r, 1'b1};
    rd_en        = 1'b0;
    rd_idx       = i_r;
    unique case (state_r)
      S_INIT: begin
        // whole heap as one free block
        wr_en     = 1'b1;
        wr_idx    = '0;
        wr_data   = {{OW{1'b0}}, OW'(HEAP_BYTES - HEADER_BYTES), 1'b1};
        count_nxt = CW'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          op_nxt  = req.opcode;
          i_nxt   = '0;
          ofs_nxt = '0;
          state_nxt = S_SC_RD;
          if (req.opcode == OP_ALLOC) begin
            need_nxt = alu_res[OW-1:0];
            if (req.req_size == 32'd0 ||
                req.req_size > 32'(HEAP_BYTES - HEADER_BYTES)) begin
              st_nxt    = ST_BAD_SIZE;
              state_nxt = S_DONE;
            end
          end else begin
            key_nxt = alu_res[OW-1:0];
            if (req.null_pointer) begin
              st_nxt    = ST_NULL;
              state_nxt = S_DONE;
            end else if (req.data_offset >= 32'(HEAP_BYTES)) begin
              st_nxt    = ST_OUTSIDE;
              state_nxt = S_DONE;
            end else if (alu_res[OW]) begin
              st_nxt    = ST_UNKNOWN;
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_SC_RD: begin
        if (i_r >= count_r) begin
          st_nxt    = (op_r == OP_ALLOC) ? ST_NO_SPACE : ST_UNKNOWN;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_SC_CK;
        end
      end
      S_SC_CK: begin
        e_start_nxt = rd_start;
        e_bytes_nxt = rd_bytes;
        if (op_r == OP_ALLOC) begin
          if (rd_free && !alu_res[OW]) begin
            if (alu_res[OW-1:0] != '0) begin
              if (count_r == CNT_MAX) begin
                st_nxt    = ST_NO_SPACE;
                state_nxt = S_DONE;
              end else begin
                diff_nxt  = alu_res[OW-1:0];
                k_nxt     = count_r;
                state_nxt = S_UP_RD;
              end
            end else begin
              // exact fit keeps its full size
              wr_en     = 1'b1;
              wr_data   = {rd_start, rd_bytes, 1'b0};
              state_nxt = S_OFS;
            end
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_SC_RD;
          end
        end else begin
          if (rd_start == key_r) begin
            if (rd_free) begin
              st_nxt    = ST_DOUBLE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_FN_RD;
            end
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_SC_RD;
          end
        end
      end
      S_UP_RD: begin
        if (k_r == i_inc) begin
          state_nxt = S_SP_A;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = k_dec;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        wr_en     = 1'b1;
        wr_idx    = k_r;
        wr_data   = rd_data;
        k_nxt     = k_dec;
        state_nxt = S_UP_RD;
      end
      S_SP_A: begin
        tmp_nxt   = alu_res[OW-1:0];
        state_nxt = S_SP_B;
      end
      S_SP_B: begin
        wr_en     = 1'b1;
        wr_idx    = i_inc;
        wr_data   = {tmp_r, diff_r, 1'b1};
        count_nxt = count_r + 1'b1;
        state_nxt = S_SP_C;
      end
      S_SP_C: begin
        wr_en     = 1'b1;
        wr_data   = {e_start_r, need_r - HDR, 1'b0};
        state_nxt = S_OFS;
      end
      S_OFS: begin
        ofs_nxt   = alu_res[OW-1:0];
        st_nxt    = ST_OK;
        state_nxt = S_DONE;
      end
      S_FN_RD: begin
        if (i_inc < count_r) begin
          rd_en     = 1'b1;
          rd_idx    = i_inc;
          state_nxt = S_FN_CK;
        end else begin
          state_nxt = S_F_WR;
        end
      end
      S_FN_CK: begin
        tmp_nxt   = alu_res[OW-1:0];
        state_nxt = rd_free ? S_FN_MG : S_F_WR;
      end
      S_FN_MG: begin
        e_bytes_nxt  = alu_res[OW-1:0];
        k_nxt        = i_inc;
        ret_done_nxt = 1'b0;
        state_nxt    = S_CL_RD;
      end
      S_F_WR: begin
        wr_en     = 1'b1;
        state_nxt = S_FP_RD;
      end
      S_FP_RD: begin
        if (i_r == '0) begin
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = i_dec;
          state_nxt = S_FP_CK;
        end
      end
      S_FP_CK: begin
        if (rd_free) begin
          tmp_nxt     = alu_res[OW-1:0];
          e_start_nxt = rd_start;
          e_bytes_nxt = rd_bytes;
          state_nxt   = S_FP_MG;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end
      end
      S_FP_MG: begin
        wr_en        = 1'b1;
        wr_idx       = i_dec;
        wr_data      = {e_start_r, alu_res[OW-1:0], 1'b1};
        k_nxt        = i_r;
        ret_done_nxt = 1'b1;
        state_nxt    = S_CL_RD;
      end
      S_CL_RD: begin
        if (k_inc >= count_r) begin
          count_nxt = count_r - 1'b1;
          if (ret_done_r) begin
            st_nxt    = ST_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_F_WR;
          end
        end else begin
          rd_en     = 1'b1;
          rd_idx    = k_inc;
          state_nxt = S_CL_WR;
        end
      end
      S_CL_WR: begin
        wr_en     = 1'b1;
        wr_idx    = k_r;
        wr_data   = rd_data;
        k_nxt     = k_inc;
        state_nxt = S_CL_RD;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      count_r    <= '0;
      ret_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ret_done_r <= ret_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    need_r    <= need_nxt;
    key_r     <= key_nxt;
    diff_r    <= diff_nxt;
    tmp_r     <= tmp_nxt;
    e_start_r <= e_start_nxt;
    e_bytes_r <= e_bytes_nxt;
    st_r      <= st_nxt;
    ofs_r     <= ofs_nxt;
  end

  assign ofs_ext          = {{OFFSET_OUT_W{1'b0}}, ofs_r};
  assign ready            = (state_r == S_IDLE);
  assign res_valid        = (state_r == S_DONE);
  assign res.status       = st_r;
  assign res.alloc_offset = ofs_ext[OFFSET_OUT_W-1:0];

endmodule

### rtl/first_fit_heap_allocator.sv
// first-fit heap allocator with coalescing over a table of heap blocks
//
// input channel: in_valid / in_stall with in_opcode (alloc or free),
// in_req_size, in_data_offset and in_null_pointer; a beat is taken when
// in_valid is high and in_stall is low
// result channel: out_valid / out_stall with out_status and
// out_alloc_offset; exactly one result beat per request beat
//
// one request at a time: in_stall stays high from the accepting edge until
// its result is handed to the output register. a table scan visits each
// entry through a read state and a check state (block table with
// registered read), and each entry moved by a split or a merge is read
// and then written back one slot over; a request rejected by its size or
// pointer checks goes straight to its result with no scan. the longest
// request is a free that merges on both sides
//
// reset: after rst_n rises the S_INIT state writes a single free block
// covering the heap into the table; in_stall is high during that state
// a stalled result holds in the output register; the next request is
// still taken and works while it waits, but its own result stays inside
// until the register frees up
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_data_offset,
  input  logic        in_null_pointer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [ffa_pkg::OFFSET_OUT_W-1:0] out_alloc_offset
);
  import ffa_pkg::*;

  req_t req;
  res_t res;
  logic ready;
  logic res_valid;
  logic res_take;

  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              out_status_r;
  logic [OFFSET_OUT_W-1:0] out_ofs_r;

  // request beat goes straight into the sequencer
  assign req.opcode       = in_opcode;
  assign req.req_size     = in_req_size;
  assign req.data_offset  = in_data_offset;
  assign req.null_pointer = in_null_pointer;

  assign in_stall = !ready;

  ffa_ctrl #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid && ready),
    .req       (req),
    .ready     (ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register: load when empty or when its beat leaves this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res.status;
      out_ofs_r    <= res.alloc_offset;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_alloc_offset = out_ofs_r;

  // a taken request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in progress");

  // only a successful allocate carries an offset
  a_offset_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_alloc_offset == '0)
    else $error("failed request reports a nonzero offset");

  // the table init cycle follows every reset
  a_init_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request accepted before table init");

  // a result beat only enters the output register when it is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !res_take)
    else $error("stalled result overwritten");

endmodule
